>>> hw/rtl/gmd_pkg.sv
// Shared types, constants and helper functions for the grid maze DFS path finder.
package gmd_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
	localparam int CELL_AW    = $clog2(CELL_COUNT);
	localparam int LEVEL_W    = 13;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int RAND_W     = 16;
	localparam int ACT_W      = 3;
	localparam int REQ_W      = 2;
	localparam int SIDE_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_ROW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_COL   = 3'd5;

	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

	localparam logic [ACT_W-1:0] ACT_IDLE      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH      = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP       = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DONE      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_EXHAUSTED = 3'd4;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ROW_W-1:0]  cell_row;
		logic [COL_W-1:0]  cell_col;
		logic [SIDE_W-1:0] open_sides;
		logic [RAND_W-1:0] rand_value;
	} in_word_t;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [ROW_W-1:0]   top_row;
		logic [COL_W-1:0]   top_col;
		logic [LEVEL_W-1:0] stack_level;
	} out_word_t;

	typedef struct packed {
		logic [3:0]  ok;
		cell_t [3:0] pos;
	} nbr_t;

	typedef struct packed {
		logic       any;
		logic [1:0] dir;
	} pick_t;

	function automatic logic [CELL_AW-1:0] cell_idx(input cell_t c);
		return CELL_AW'(int'(c.row) * MAX_COLS + int'(c.col));
	endfunction

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int lim);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (int'(v) > lim) begin
			r = CFG_W'(lim);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// base-4 digit sum, then fold twice (4 = 1 mod 3)
	function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
		logic [4:0] s;
		logic [3:0] t;
		logic [2:0] u;
		s = '0;
		for (int i = 0; i < RAND_W / 2; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 4'(s[4:2]) + 4'(s[1:0]);
		u = 3'(t[3:2]) + 3'(t[1:0]);
		if (u >= 3'd3) begin
			u = u - 3'd3;
		end
		return u[1:0];
	endfunction

endpackage

>>> hw/rtl/gmd_ram.sv
// Generic simple dual-port RAM with registered read.
module gmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/gmd_nbr.sv
// Neighbor cells of the stack top and whether each lies inside the grid in use.
module gmd_nbr (
	input  gmd_pkg::cell_t                top,
	input  logic [gmd_pkg::CFG_W-1:0]     rows,
	input  logic [gmd_pkg::CFG_W-1:0]     cols,
	output gmd_pkg::nbr_t                 nbr
);

	logic [gmd_pkg::CFG_W-1:0] r7;
	logic [gmd_pkg::CFG_W-1:0] c7;

	assign r7 = gmd_pkg::CFG_W'(top.row);
	assign c7 = gmd_pkg::CFG_W'(top.col);

	always_comb begin
		nbr.ok[gmd_pkg::DIR_N] = (top.row != '0) && ((r7 - 1'b1) < rows) && (c7 < cols);
		nbr.ok[gmd_pkg::DIR_E] = (r7 < rows) && ((c7 + 1'b1) < cols);
		nbr.ok[gmd_pkg::DIR_S] = ((r7 + 1'b1) < rows) && (c7 < cols);
		nbr.ok[gmd_pkg::DIR_W] = (r7 < rows) && (top.col != '0) && ((c7 - 1'b1) < cols);

		nbr.pos[gmd_pkg::DIR_N].row = top.row - 1'b1;
		nbr.pos[gmd_pkg::DIR_N].col = top.col;
		nbr.pos[gmd_pkg::DIR_E].row = top.row;
		nbr.pos[gmd_pkg::DIR_E].col = top.col + 1'b1;
		nbr.pos[gmd_pkg::DIR_S].row = top.row + 1'b1;
		nbr.pos[gmd_pkg::DIR_S].col = top.col;
		nbr.pos[gmd_pkg::DIR_W].row = top.row;
		nbr.pos[gmd_pkg::DIR_W].col = top.col - 1'b1;
	end

endmodule

>>> hw/rtl/gmd_pick.sv
// Chooses the viable neighbor at position rand mod count, in N,E,S,W order.
module gmd_pick (
	input  logic [3:0]      cand,
	input  logic [1:0]      rnd_lo,
	input  logic [1:0]      rmod3,
	output gmd_pkg::pick_t  pick
);

	logic [2:0] n;
	logic [1:0] k;
	logic [1:0] seen;
	logic       found;

	assign n = 3'($countones(cand));

	always_comb begin
		case (n)
			3'd4: k = rnd_lo;
			3'd3: k = rmod3;
			3'd2: k = {1'b0, rnd_lo[0]};
			default: k = 2'd0;
		endcase
	end

	always_comb begin
		seen     = '0;
		found    = 1'b0;
		pick.any = |cand;
		pick.dir = gmd_pkg::DIR_N;
		for (int i = 0; i < 4; i++) begin
			if (cand[i] && !found) begin
				if (seen == k) begin
					pick.dir = 2'(i);
					found    = 1'b1;
				end
				seen = seen + 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/grid_maze_dfs_path_finder_top.sv
// Grid maze DFS path finder: control sequencer, config registers and the three memories.
// Load and unknown requests, and a step on an empty stack or at the exit, reply directly; a
// search step reads the visited memory once per neighbor, then pushes or pops; a pop that
// leaves the stack non-empty reads the new top back from the stack memory. Start clears the
// visited memory first. One word is in work at a time; a finished word waits in the output
// register meanwhile. Reset clears control state, then a visited clear runs with in_stall high.
module grid_maze_dfs_path_finder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gmd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gmd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  gmd_pkg::in_word_t             in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output gmd_pkg::out_word_t            out_word
);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_PROBE  = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_POPRD  = 7'b0010000,
		S_START  = 7'b0100000,
		S_REPLY  = 7'b1000000
	} state_t;

	state_t                             state_q;
	logic [gmd_pkg::CFG_W-1:0]          num_rows_q;
	logic [gmd_pkg::CFG_W-1:0]          num_cols_q;
	logic [gmd_pkg::ROW_W-1:0]          start_row_q;
	logic [gmd_pkg::COL_W-1:0]          start_col_q;
	logic [gmd_pkg::ROW_W-1:0]          end_row_q;
	logic [gmd_pkg::COL_W-1:0]          end_col_q;
	logic [gmd_pkg::CELL_AW-1:0]        clr_q;
	logic                               clr_start_q;
	logic [gmd_pkg::LEVEL_W-1:0]        count_q;
	gmd_pkg::cell_t                     top_q;
	logic [gmd_pkg::ACT_W-1:0]          act_q;
	logic [1:0]                         rnd_q;
	logic [1:0]                         rmod3_q;
	gmd_pkg::nbr_t                      nbr_q;
	logic [1:0]                         dir_q;
	logic [2:0]                         cand_q;
	logic                               out_valid_q;
	gmd_pkg::out_word_t                 out_word_q;

	logic                               in_acc;
	logic                               out_free;
	logic [gmd_pkg::CFG_W-1:0]          rows_use;
	logic [gmd_pkg::CFG_W-1:0]          cols_use;
	gmd_pkg::nbr_t                      nbr;
	gmd_pkg::pick_t                     pick;
	logic [3:0]                         cand;
	gmd_pkg::cell_t                     start_cell;
	gmd_pkg::cell_t                     load_cell;
	logic                               start_ok;
	logic                               load_ok;
	logic                               at_end;
	logic                               do_push;
	logic [gmd_pkg::LEVEL_W-1:0]        lvl_m2;

	logic [gmd_pkg::SIDE_W-1:0]         walls_rdata;
	logic                               walls_we;
	logic                               walls_re;
	logic                               vis_we;
	logic [gmd_pkg::CELL_AW-1:0]        vis_waddr;
	logic                               vis_wdata;
	logic                               vis_re;
	logic                               vis_rdata;
	logic                               stk_we;
	logic [gmd_pkg::CELL_AW-1:0]        stk_waddr;
	logic [gmd_pkg::CELL_W-1:0]         stk_wdata;
	logic                               stk_re;
	logic [gmd_pkg::CELL_W-1:0]         stk_rdata;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign rows_use = gmd_pkg::clamp_dim(num_rows_q, gmd_pkg::MAX_ROWS);
	assign cols_use = gmd_pkg::clamp_dim(num_cols_q, gmd_pkg::MAX_COLS);

	assign start_cell.row = start_row_q;
	assign start_cell.col = start_col_q;
	assign load_cell.row  = in_word.cell_row;
	assign load_cell.col  = in_word.cell_col;

	assign start_ok = (gmd_pkg::CFG_W'(start_row_q) < rows_use) &&
	                  (gmd_pkg::CFG_W'(start_col_q) < cols_use);
	assign load_ok  = (int'(in_word.cell_row) < gmd_pkg::MAX_ROWS) &&
	                  (int'(in_word.cell_col) < gmd_pkg::MAX_COLS);
	assign at_end   = (top_q.row == end_row_q) && (top_q.col == end_col_q);
	assign lvl_m2   = count_q - gmd_pkg::LEVEL_W'(2);

	assign cand    = {nbr_q.ok[gmd_pkg::DIR_W] && walls_rdata[gmd_pkg::DIR_W] && !vis_rdata,
	                  cand_q};
	assign do_push = pick.any && (count_q < gmd_pkg::LEVEL_W'(gmd_pkg::CELL_COUNT));

	gmd_nbr u_nbr (
		.top  (top_q),
		.rows (rows_use),
		.cols (cols_use),
		.nbr  (nbr)
	);

	gmd_pick u_pick (
		.cand   (cand),
		.rnd_lo (rnd_q),
		.rmod3  (rmod3_q),
		.pick   (pick)
	);

	// memory ports
	assign walls_we = in_acc && (in_word.req_type == gmd_pkg::REQ_LOAD) && load_ok;
	assign walls_re = in_acc && (in_word.req_type == gmd_pkg::REQ_STEP);

	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = clr_q;
		vis_wdata = 1'b0;
		stk_we    = 1'b0;
		stk_waddr = count_q[gmd_pkg::CELL_AW-1:0];
		stk_wdata = start_cell;
		stk_re    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				vis_we = 1'b1;
			end
			S_START: begin
				vis_we    = start_ok;
				vis_waddr = gmd_pkg::cell_idx(start_cell);
				vis_wdata = 1'b1;
				stk_we    = start_ok;
				stk_waddr = '0;
			end
			S_DECIDE: begin
				vis_we    = do_push;
				vis_waddr = gmd_pkg::cell_idx(nbr_q.pos[pick.dir]);
				vis_wdata = 1'b1;
				stk_we    = do_push;
				stk_wdata = nbr_q.pos[pick.dir];
				stk_re    = !do_push && (count_q > gmd_pkg::LEVEL_W'(1));
			end
			default: begin
			end
		endcase
	end

	assign vis_re = (state_q == S_PROBE);

	gmd_ram #(
		.WIDTH (gmd_pkg::SIDE_W),
		.DEPTH (gmd_pkg::CELL_COUNT)
	) u_walls (
		.clk   (clk),
		.we    (walls_we),
		.waddr (gmd_pkg::cell_idx(load_cell)),
		.wdata (in_word.open_sides),
		.re    (walls_re),
		.raddr (gmd_pkg::cell_idx(top_q)),
		.rdata (walls_rdata)
	);

	gmd_ram #(
		.WIDTH (1),
		.DEPTH (gmd_pkg::CELL_COUNT)
	) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (vis_re),
		.raddr (gmd_pkg::cell_idx(nbr_q.pos[dir_q])),
		.rdata (vis_rdata)
	);

	gmd_ram #(
		.WIDTH (gmd_pkg::CELL_W),
		.DEPTH (gmd_pkg::CELL_COUNT)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (lvl_m2[gmd_pkg::CELL_AW-1:0]),
		.rdata (stk_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= gmd_pkg::CFG_W'(16);
			num_cols_q  <= gmd_pkg::CFG_W'(16);
			start_row_q <= '0;
			start_col_q <= '0;
			end_row_q   <= gmd_pkg::ROW_W'(15);
			end_col_q   <= gmd_pkg::COL_W'(15);
		end else if (cfg_we) begin
			case (cfg_idx)
				gmd_pkg::REG_NUM_ROWS:  num_rows_q  <= cfg_data;
				gmd_pkg::REG_NUM_COLS:  num_cols_q  <= cfg_data;
				gmd_pkg::REG_START_ROW: start_row_q <= cfg_data[gmd_pkg::ROW_W-1:0];
				gmd_pkg::REG_START_COL: start_col_q <= cfg_data[gmd_pkg::COL_W-1:0];
				gmd_pkg::REG_END_ROW:   end_row_q   <= cfg_data[gmd_pkg::ROW_W-1:0];
				gmd_pkg::REG_END_COL:   end_col_q   <= cfg_data[gmd_pkg::COL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			clr_start_q <= 1'b0;
			count_q     <= '0;
			top_q       <= '0;
			act_q       <= gmd_pkg::ACT_IDLE;
			dir_q       <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == gmd_pkg::CELL_AW'(gmd_pkg::CELL_COUNT - 1)) begin
						state_q <= clr_start_q ? S_START : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						case (in_word.req_type)
							gmd_pkg::REQ_START: begin
								clr_q       <= '0;
								clr_start_q <= 1'b1;
								count_q     <= '0;
								top_q       <= '0;
								state_q     <= S_CLEAR;
							end
							gmd_pkg::REQ_STEP: begin
								if (count_q == '0) begin
									act_q   <= gmd_pkg::ACT_EXHAUSTED;
									state_q <= S_REPLY;
								end else if (at_end) begin
									act_q   <= gmd_pkg::ACT_DONE;
									state_q <= S_REPLY;
								end else begin
									rnd_q   <= in_word.rand_value[1:0];
									rmod3_q <= gmd_pkg::mod3_16(in_word.rand_value);
									nbr_q   <= nbr;
									dir_q   <= gmd_pkg::DIR_N;
									state_q <= S_PROBE;
								end
							end
							default: begin
								act_q   <= gmd_pkg::ACT_IDLE;
								state_q <= S_REPLY;
							end
						endcase
					end
				end
				S_PROBE: begin
					if (dir_q != gmd_pkg::DIR_N) begin
						cand_q[dir_q - 1'b1] <= nbr_q.ok[dir_q - 1'b1] &&
						                        walls_rdata[dir_q - 1'b1] && !vis_rdata;
					end
					dir_q <= dir_q + 1'b1;
					if (dir_q == gmd_pkg::DIR_W) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (do_push) begin
						act_q   <= gmd_pkg::ACT_PUSH;
						top_q   <= nbr_q.pos[pick.dir];
						count_q <= count_q + 1'b1;
						state_q <= S_REPLY;
					end else begin
						act_q   <= gmd_pkg::ACT_POP;
						count_q <= count_q - 1'b1;
						if (count_q > gmd_pkg::LEVEL_W'(1)) begin
							state_q <= S_POPRD;
						end else begin
							top_q   <= '0;
							state_q <= S_REPLY;
						end
					end
				end
				S_POPRD: begin
					top_q   <= gmd_pkg::cell_t'(stk_rdata);
					state_q <= S_REPLY;
				end
				S_START: begin
					clr_start_q <= 1'b0;
					state_q     <= S_REPLY;
					if (start_ok) begin
						act_q   <= gmd_pkg::ACT_IDLE;
						top_q   <= start_cell;
						count_q <= gmd_pkg::LEVEL_W'(1);
					end else begin
						act_q <= gmd_pkg::ACT_EXHAUSTED;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_REPLY) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_REPLY) && out_free) begin
			out_word_q.action      <= act_q;
			out_word_q.top_row     <= top_q.row;
			out_word_q.top_col     <= top_q.col;
			out_word_q.stack_level <= count_q;
		end
	end

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gmd_pkg::LEVEL_W'(gmd_pkg::CELL_COUNT))
		else $error("stack level beyond depth");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (top_q == '0))
		else $error("empty stack with nonzero top");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DECIDE) && do_push) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not raise the level");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("accepted word did not occupy the sequencer");

	a_reply_loads: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_REPLY) && out_free) |=> out_valid_q)
		else $error("reply not placed in output register");
`endif

endmodule
